// File: rtl/art_pkg.sv
// shared types, constants and byte functions for the aes round transform
// depends on nothing; used by every module in rtl
`timescale 1ns / 1ps
package art_pkg;

  typedef enum logic [2:0] {
    KIND_ENC_ROUND = 3'd0,
    KIND_ENC_LAST  = 3'd1,
    KIND_DEC_ROUND = 3'd2,
    KIND_DEC_LAST  = 3'd3,
    KIND_MIX       = 3'd4,
    KIND_INV_MIX   = 3'd5,
    KIND_PASS6     = 3'd6,
    KIND_PASS7     = 3'd7
  } kind_t;

  typedef logic [7:0] byte_t;
  typedef byte_t [15:0] state_t;

  // lane control, one flag set per stage
  typedef struct packed {
    logic do_sub;
    logic do_mix;
    logic inverse;
  } lane_ctl_t;

  localparam byte_t REDUCE = 8'h1b;

  localparam logic [3:0] FWD_SHIFT [16] = '{4'd0, 4'd5, 4'd10, 4'd15, 4'd4, 4'd9, 4'd14, 4'd3,
                                            4'd8, 4'd13, 4'd2, 4'd7, 4'd12, 4'd1, 4'd6, 4'd11};
  localparam logic [3:0] INV_SHIFT [16] = '{4'd0, 4'd13, 4'd10, 4'd7, 4'd4, 4'd1, 4'd14, 4'd11,
                                            4'd8, 4'd5, 4'd2, 4'd15, 4'd12, 4'd9, 4'd6, 4'd3};

  function automatic byte_t xtime(input byte_t a);
    xtime = a[7] ? ((a << 1) ^ REDUCE) : (a << 1);
  endfunction

  function automatic byte_t gmul(input byte_t a, input byte_t b);
    byte_t acc;
    byte_t x;
    acc = '0;
    x = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc = acc ^ x;
      x = xtime(x);
    end
    gmul = acc;
  endfunction

  function automatic byte_t ginv(input byte_t a);
    byte_t r;
    byte_t base;
    logic [7:0] e;
    r = 8'h01;
    base = a;
    e = 8'd254;
    for (int k = 0; k < 8; k++) begin
      if (e[k]) r = gmul(r, base);
      base = gmul(base, base);
    end
    ginv = r;
  endfunction

  function automatic byte_t rotl(input byte_t v, input int n);
    rotl = byte_t'((v << n) | (v >> (8 - n)));
  endfunction

  function automatic byte_t sbox_f(input byte_t a);
    byte_t b;
    b = ginv(a);
    sbox_f = b ^ rotl(b, 1) ^ rotl(b, 2) ^ rotl(b, 3) ^ rotl(b, 4) ^ 8'h63;
  endfunction

  function automatic byte_t inv_sbox_f(input byte_t s);
    inv_sbox_f = ginv(rotl(s, 1) ^ rotl(s, 3) ^ rotl(s, 6) ^ 8'h05);
  endfunction

  // both tables are built at elaboration and read as constant logic
  function automatic state_t [15:0] fwd_tab_f();
    state_t [15:0] r;
    for (int i = 0; i < 256; i++) r[i / 16][i % 16] = sbox_f(byte_t'(i));
    fwd_tab_f = r;
  endfunction

  function automatic state_t [15:0] inv_tab_f();
    state_t [15:0] r;
    for (int i = 0; i < 256; i++) r[i / 16][i % 16] = inv_sbox_f(byte_t'(i));
    inv_tab_f = r;
  endfunction

  localparam state_t [15:0] SBOX_TAB = fwd_tab_f();
  localparam state_t [15:0] INV_SBOX_TAB = inv_tab_f();

endpackage

// File: rtl/art_sub_lane.sv
// one byte lane of the substitution stage: forward or inverse s-box lookup
// depends on art_pkg
`timescale 1ns / 1ps
module art_sub_lane (
  input  art_pkg::byte_t     din,
  input  art_pkg::lane_ctl_t ctl,
  output art_pkg::byte_t     dout
);
  art_pkg::byte_t fwd;
  art_pkg::byte_t inv;

  assign fwd = art_pkg::SBOX_TAB[din[7:4]][din[3:0]];
  assign inv = art_pkg::INV_SBOX_TAB[din[7:4]][din[3:0]];
  assign dout = !ctl.do_sub ? din : (ctl.inverse ? inv : fwd);
endmodule

// File: rtl/art_mix_lane.sv
// one column lane of the mixing stage: mixcolumns or its inverse
// depends on art_pkg
`timescale 1ns / 1ps
module art_mix_lane (
  input  art_pkg::byte_t [3:0] din,
  input  art_pkg::lane_ctl_t   ctl,
  output art_pkg::byte_t [3:0] dout
);
  art_pkg::byte_t [3:0] fwd;
  art_pkg::byte_t [3:0] inv;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      fwd[r] = art_pkg::xtime(din[r]) ^ art_pkg::xtime(din[(r + 1) % 4]) ^ din[(r + 1) % 4]
             ^ din[(r + 2) % 4] ^ din[(r + 3) % 4];
      inv[r] = art_pkg::gmul(8'h0e, din[r]) ^ art_pkg::gmul(8'h0b, din[(r + 1) % 4])
             ^ art_pkg::gmul(8'h0d, din[(r + 2) % 4]) ^ art_pkg::gmul(8'h09, din[(r + 3) % 4]);
    end
  end

  assign dout = !ctl.do_mix ? din : (ctl.inverse ? inv : fwd);
endmodule

// File: rtl/aes_round_transform_core.sv
// top level: two-stage pipeline of 16 s-box lanes and 4 mixcolumn lanes
// depends on art_pkg, art_sub_lane, art_mix_lane
`timescale 1ns / 1ps
// usage:
//   s_axis carries one state per item; tuser holds kind (3 bits), tdata holds
//   state_low in bits 63:0 and state_high in bits 127:64.
//   m_axis returns the transformed state in tdata the same way.
//   the block is a two-stage pipeline: stage one does the row shift and the
//   16 parallel s-box lanes, stage two the 4 parallel column-mix lanes and
//   merges the lanes back into one state.
//   throughput is one item per cycle while m_axis does not stall. a stall on
//   m_axis holds stage two, and stage one too once it holds an item;
//   s_axis_tready follows the free slot of stage one, so an item is still
//   taken while a result waits if stage one is empty.
//   kind codes 6 and 7 pass the state through unchanged.
//   rst clears both valid flags; payload registers are not reset.
module aes_round_transform_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // state_low [63:0], state_high [127:64]
  input  logic [2:0]   s_axis_tuser,   // kind [2:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata    // result_low [63:0], result_high [127:64]
);
  art_pkg::state_t    in_st;
  art_pkg::state_t    shifted;
  art_pkg::state_t    subbed;
  art_pkg::state_t    st1;
  art_pkg::state_t    mixed;
  art_pkg::state_t    st2;
  art_pkg::lane_ctl_t ctl_in;
  art_pkg::lane_ctl_t ctl1;
  logic               v1;
  logic               v2;
  logic               adv2;
  logic               adv1;

  assign in_st = s_axis_tdata;

  always_comb begin
    ctl_in = '0;
    case (art_pkg::kind_t'(s_axis_tuser))
      art_pkg::KIND_ENC_ROUND: ctl_in = '{do_sub: 1'b1, do_mix: 1'b1, inverse: 1'b0};
      art_pkg::KIND_ENC_LAST:  ctl_in = '{do_sub: 1'b1, do_mix: 1'b0, inverse: 1'b0};
      art_pkg::KIND_DEC_ROUND: ctl_in = '{do_sub: 1'b1, do_mix: 1'b1, inverse: 1'b1};
      art_pkg::KIND_DEC_LAST:  ctl_in = '{do_sub: 1'b1, do_mix: 1'b0, inverse: 1'b1};
      art_pkg::KIND_MIX:       ctl_in = '{do_sub: 1'b0, do_mix: 1'b1, inverse: 1'b0};
      art_pkg::KIND_INV_MIX:   ctl_in = '{do_sub: 1'b0, do_mix: 1'b1, inverse: 1'b1};
      default:                 ctl_in = '0;
    endcase
  end

  // row shift only when a substitution goes with it
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      if (!ctl_in.do_sub) shifted[i] = in_st[i];
      else if (ctl_in.inverse) shifted[i] = in_st[art_pkg::INV_SHIFT[i]];
      else shifted[i] = in_st[art_pkg::FWD_SHIFT[i]];
    end
  end

  for (genvar g = 0; g < 16; g++) begin : g_sub
    art_sub_lane u_sub (.din(shifted[g]), .ctl(ctl_in), .dout(subbed[g]));
  end

  for (genvar c = 0; c < 4; c++) begin : g_mix
    art_mix_lane u_mix (.din(st1[4*c +: 4]), .ctl(ctl1), .dout(mixed[4*c +: 4]));
  end

  assign adv2 = !v2 || m_axis_tready;
  assign adv1 = !v1 || adv2;
  assign s_axis_tready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (adv1) v1 <= s_axis_tvalid;
      if (adv2) v2 <= v1;
    end
    if (adv1 && s_axis_tvalid) begin
      st1 <= subbed;
      ctl1 <= ctl_in;
    end
    if (adv2 && v1) st2 <= mixed;
  end

  assign m_axis_tvalid = v2;
  assign m_axis_tdata = st2;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !v1 |-> s_axis_tready)
    else $error("empty stage refused an item");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    v1 && !v2 |=> v2)
    else $error("stage one item lost");
endmodule
